[design/taa_pkg.sv]
// ----------------------------------------------------------------------------
// Temporal activity accumulator package
// Shared widths, register indexes and queue sizing for the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package taa_pkg;

    // Configuration register widths.
    localparam int ORDER_W = 2;
    localparam int WIDTH_W = 9;
    localparam int GAMMA_W = 4;
    localparam int CFG_W   = 9;

    // Accumulator and result widths.
    localparam int SUM_W = 40;
    localparam int ACT_W = 44;

    // Result queue depth; also the number of results that may be outstanding.
    localparam int RESULT_DEPTH = 4;
    localparam int RQ_PTR_W     = 2;
    localparam int RQ_CNT_W     = 3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DIFF_ORDER  = 2'd0,
        REG_DOWNSAMPLE  = 2'd1,
        REG_BLOCK_WIDTH = 2'd2,
        REG_GAMMA       = 2'd3
    } cfg_reg_t;

endpackage : taa_pkg

`default_nettype wire

[design/taa_result_queue.sv]
// ----------------------------------------------------------------------------
// Result queue
// Small first-in first-out store between the product stage and the output
// channel, so that results wait here while the input side keeps running.
// ----------------------------------------------------------------------------
`default_nettype none

module taa_result_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic [taa_pkg::ACT_W-1:0] push_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [taa_pkg::ACT_W-1:0]      activity
);
    import taa_pkg::*;

    logic [ACT_W-1:0]    entry_reg [RESULT_DEPTH];
    logic [RQ_PTR_W-1:0] head_reg;
    logic [RQ_PTR_W-1:0] tail_reg;
    logic [RQ_CNT_W-1:0] count_reg;
    logic [RQ_CNT_W-1:0] count_next;
    logic                pop;

    // An item leaves when it is shown and the sink does not stall.
    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != '0);
    assign activity  = entry_reg[head_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + RQ_CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - RQ_CNT_W'(1);
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + RQ_PTR_W'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + RQ_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage; entries carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

endmodule : taa_result_queue

`default_nettype wire

[design/temporal_activity_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// Temporal activity accumulator
// Sums absolute temporal pixel differences over one block, optionally over
// 2x2 quads through a line store, and emits the sum times gamma at block end.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_write, cfg_index, cfg_data           | in
//  in      | in_valid/in_stall, cur_pixel, prev_pixel,| in
//          | prev2_pixel, last_pixel                  |
//  out     | out_valid/out_stall, activity            | out
//
//  One pixel item is taken per cycle while in_stall is low. A result
//  goes through three steps after its last pixel is taken: line store
//  read, accumulate, multiply by gamma. The line store is read in the accept
//  cycle and its data is used in the next cycle. An even-row write always
//  lands before the odd-row read of that entry, so no forwarding is needed.
//  Up to four results may wait in the result queue; the input stalls only
//  when four results are outstanding. Reset clears all control state; the
//  line store has no reset and needs none.
//
`default_nettype none

module temporal_activity_accumulator_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int PIXEL_BITS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration write port.
    input  wire logic                        cfg_write,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [taa_pkg::CFG_W-1:0]   cfg_data,
    // Pixel items.
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [PIXEL_BITS-1:0]       cur_pixel,
    input  wire logic [PIXEL_BITS-1:0]       prev_pixel,
    input  wire logic [PIXEL_BITS-1:0]       prev2_pixel,
    input  wire logic                        last_pixel,
    // Result items.
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [taa_pkg::ACT_W-1:0]        activity
);
    import taa_pkg::*;

    localparam int DIFF_W     = PIXEL_BITS + 2;
    localparam int PAIR_W     = PIXEL_BITS + 3;
    localparam int QUAD_W     = PIXEL_BITS + 4;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // Configuration registers.
    logic [ORDER_W-1:0] diff_order_reg;
    logic               downsample_reg;
    logic [WIDTH_W-1:0] block_width_reg;
    logic [GAMMA_W-1:0] gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_order_reg  <= ORDER_W'(1);
            downsample_reg  <= 1'b0;
            block_width_reg <= WIDTH_W'(16);
            gamma_reg       <= GAMMA_W'(2);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIFF_ORDER:  diff_order_reg  <= cfg_data[ORDER_W-1:0];
                REG_DOWNSAMPLE:  downsample_reg  <= cfg_data[0];
                REG_BLOCK_WIDTH: block_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_GAMMA:       gamma_reg       <= cfg_data[GAMMA_W-1:0];
                default:         diff_order_reg  <= diff_order_reg;
            endcase
        end
    end

    // Input handshake: stall only when every result slot is spoken for.
    logic               accept;
    logic [RQ_CNT_W-1:0] credit_reg;
    logic                pop;

    assign in_stall = (credit_reg == RQ_CNT_W'(RESULT_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            if (accept && last_pixel && !pop)
            begin
                credit_reg <= credit_reg + RQ_CNT_W'(1);
            end
            else if (pop && !(accept && last_pixel))
            begin
                credit_reg <= credit_reg - RQ_CNT_W'(1);
            end
        end
    end

    // Effective row width, limited to the supported range.
    logic [WIDTH_W-1:0] width_eff;

    always_comb
    begin
        priority if (block_width_reg < WIDTH_W'(2))
        begin
            width_eff = WIDTH_W'(2);
        end
        else if (32'(block_width_reg) > MAX_WIDTH)
        begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = block_width_reg;
        end
    end

    // Temporal difference of the incoming pixel.
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] cur_s;
    logic signed [DIFF_W-1:0] prev_s;
    logic signed [DIFF_W-1:0] prev2_s;

    assign cur_s   = signed'({2'b00, cur_pixel});
    assign prev_s  = signed'({2'b00, prev_pixel});
    assign prev2_s = signed'({2'b00, prev2_pixel});
    assign diff    = diff_order_reg[1] ? (cur_s - (prev_s <<< 1) + prev2_s)
                                       : (cur_s - prev_s);

    // Position in the block and pair forming.
    logic [WIDTH_W-1:0]       col_reg;
    logic [WIDTH_W-1:0]       col_inc;
    logic                     odd_row_reg;
    logic signed [DIFF_W-1:0] pair_partial_reg;
    logic signed [PAIR_W-1:0] pair_sum;
    logic                     col_odd;
    logic [ADDR_W-1:0]        slot;
    logic                     mem_we;
    logic                     mem_re;
    logic                     term_acc;

    assign col_inc  = col_reg + WIDTH_W'(1);
    assign col_odd  = col_reg[0];
    assign slot     = ADDR_W'(col_reg[WIDTH_W-1:1]);
    assign pair_sum = PAIR_W'(pair_partial_reg) + PAIR_W'(diff);
    assign mem_we   = accept && downsample_reg && col_odd && !odd_row_reg;
    assign mem_re   = accept && downsample_reg && col_odd && odd_row_reg;
    assign term_acc = !downsample_reg || (col_odd && odd_row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            odd_row_reg      <= 1'b0;
            pair_partial_reg <= '0;
        end
        else if (accept)
        begin
            priority if (last_pixel)
            begin
                col_reg          <= '0;
                odd_row_reg      <= 1'b0;
                pair_partial_reg <= '0;
            end
            else if (col_inc >= width_eff)
            begin
                col_reg          <= '0;
                odd_row_reg      <= !odd_row_reg;
                pair_partial_reg <= '0;
            end
            else
            begin
                col_reg <= col_inc;
                if (downsample_reg && !col_odd)
                begin
                    pair_partial_reg <= diff;
                end
            end
        end
    end

    // Line store of even-row pair sums.
    logic signed [PAIR_W-1:0] line_mem [LINE_DEPTH];
    logic signed [PAIR_W-1:0] line_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[slot] <= pair_sum;
        end
        if (mem_re)
        begin
            line_rdata_reg <= line_mem[slot];
        end
    end

    // Stage 1 registers: the term waiting to be accumulated.
    logic                     s1_acc_reg;
    logic                     s1_mem_reg;
    logic                     s1_last_reg;
    logic signed [PAIR_W-1:0] s1_term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_acc_reg  <= 1'b0;
            s1_mem_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
        end
        else
        begin
            s1_acc_reg  <= accept && term_acc;
            s1_mem_reg  <= mem_re;
            s1_last_reg <= accept && last_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_term_reg <= downsample_reg ? pair_sum : PAIR_W'(diff);
        end
    end

    // Absolute value and saturating accumulation.
    logic signed [QUAD_W-1:0] quad;
    logic [QUAD_W-1:0]        mag;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_acc;
    logic [SUM_W-1:0]         sum_reg;

    assign quad     = s1_mem_reg ? (QUAD_W'(line_rdata_reg) + QUAD_W'(s1_term_reg))
                                 : QUAD_W'(s1_term_reg);
    assign mag      = quad[QUAD_W-1] ? QUAD_W'(-quad) : QUAD_W'(quad);
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(mag);
    assign sum_acc  = !s1_acc_reg ? sum_reg
                    : (sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0]);

    logic             fin_valid_reg;
    logic [SUM_W-1:0] fin_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= s1_last_reg ? '0 : sum_acc;
            fin_valid_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_last_reg)
        begin
            fin_sum_reg <= sum_acc;
        end
    end

    // Gamma scaling; the product is registered in the result queue.
    logic [ACT_W-1:0] product;

    assign product = ACT_W'(fin_sum_reg) * ACT_W'(gamma_reg);

    taa_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fin_valid_reg),
        .push_data (product),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .activity  (activity)
    );

`ifndef SYNTH
    // Outstanding results never exceed the queue depth.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= RQ_CNT_W'(RESULT_DEPTH))
        else $error("result credit above queue depth");

    // A shown result always has a credit behind it.
    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_reg != '0))
        else $error("result shown without outstanding credit");

    // The accumulator is clear after a block ends.
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_last_reg |=> (sum_reg == '0))
        else $error("accumulator not cleared after block end");

    // The line store is never written and read in the same cycle.
    a_mem_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("line store written and read together");

    // A line store read is always followed by an accumulation of its data.
    a_read_used: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (s1_mem_reg && s1_acc_reg))
        else $error("line store data not accumulated");
`endif

endmodule : temporal_activity_accumulator_unit

`default_nettype wire
